@@ hdl/sfv_pkg.sv @@
// shared types, constants and the character class function for the
// 8.3 short name checker; no dependencies
package sfv_pkg;

   // name rule limits
   localparam int unsigned MaxNameLen  = 12;
   localparam int unsigned BaseLen     = 8;
   localparam int unsigned ExtLen      = 3;
   localparam logic [7:0]  CaseOffset  = 8'd32;
   localparam logic [7:0]  SpaceByte   = 8'h20;
   localparam logic [7:0]  DotByte     = 8'h2e;
   localparam logic [3:0]  CharCountSat = 4'd13;
   localparam logic [3:0]  BaseCountSat = 4'd9;
   localparam logic [2:0]  ExtCountSat  = 3'd4;
   localparam logic [63:0] BaseSpaces  = {8{SpaceByte}};
   localparam logic [23:0] ExtSpaces   = {3{SpaceByte}};

   // special characters allowed besides letters and digits
   localparam int unsigned SpecialCount = 16;
   localparam logic [7:0] SpecialSet [SpecialCount] = '{
      8'h24, 8'h25, 8'h27, 8'h2d, 8'h5f, 8'h40, 8'h7e, 8'h60,
      8'h21, 8'h28, 8'h29, 8'h7b, 8'h7d, 8'h5e, 8'h23, 8'h26
   };

   // classification of one character
   typedef struct packed {
      logic       up;
      logic       lo;
      logic       allowed;
      logic       is_dot;
      logic [7:0] folded;
   } char_class_type;

   // one result item
   typedef struct packed {
      logic        valid_res;
      logic        lower_base;
      logic        lower_ext;
      logic [63:0] base_name;
      logic [23:0] ext_name;
   } rsp_type;

   function automatic logic in_special_set(input logic [7:0] c);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < SpecialCount; i++) begin
         if (SpecialSet[i] == c) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

@@ hdl/sfv_if.sv @@
// valid/ready channel interfaces for the name characters and the results;
// depends on nothing
interface sfv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

interface sfv_rsp_if;
   logic        valid;
   logic        ready;
   logic        valid_res;
   logic        lower_base;
   logic        lower_ext;
   logic [63:0] base_name;
   logic [23:0] ext_name;

   modport source (output valid, output valid_res, output lower_base, output lower_ext,
                   output base_name, output ext_name, input ready);
   modport sink   (input valid, input valid_res, input lower_base, input lower_ext,
                   input base_name, input ext_name, output ready);
endinterface

@@ hdl/sfv_char_class.sv @@
// combinational classifier for one name character: case, allowed set,
// dot and upper-case fold; depends on sfv_pkg
module sfv_char_class (
   input  logic [7:0]              ch,
   output sfv_pkg::char_class_type cls
);

   logic up;
   logic lo;
   logic dig;

   // letter and digit ranges
   assign up  = (ch >= 8'h41) && (ch <= 8'h5a);
   assign lo  = (ch >= 8'h61) && (ch <= 8'h7a);
   assign dig = (ch >= 8'h30) && (ch <= 8'h39);

   // pack the class
   always_comb begin
      cls.up      = up;
      cls.lo      = lo;
      cls.allowed = up || lo || dig || sfv_pkg::in_special_set(ch);
      cls.is_dot  = (ch == sfv_pkg::DotByte);
      cls.folded  = lo ? (ch - sfv_pkg::CaseOffset) : ch;
   end

endmodule

@@ hdl/sfv_name_accum.sv @@
// per-name state: counters, case flags and formatted base/extension bytes;
// forms the result on the last character; depends on sfv_pkg
module sfv_name_accum (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    last,
   input  sfv_pkg::char_class_type cls,
   output logic                    push,
   output sfv_pkg::rsp_type        result
);

   logic [3:0]  char_count_ff, char_count_in;
   logic        dot_seen_ff, dot_seen_in;
   logic [3:0]  base_count_ff, base_count_in;
   logic [2:0]  ext_count_ff, ext_count_in;
   logic        bad_char_ff, bad_char_in;
   logic [3:0]  case_flags_ff, case_flags_in;
   logic [1:0]  lower_flags_ff, lower_flags_in;
   logic [63:0] base_accum_ff, base_accum_in;
   logic [23:0] ext_accum_ff, ext_accum_in;

   // next state for one character
   always_comb begin
      char_count_in  = char_count_ff;
      dot_seen_in    = dot_seen_ff;
      base_count_in  = base_count_ff;
      ext_count_in   = ext_count_ff;
      bad_char_in    = bad_char_ff;
      case_flags_in  = case_flags_ff;
      lower_flags_in = lower_flags_ff;
      base_accum_in  = base_accum_ff;
      ext_accum_in   = ext_accum_ff;

      if (char_count_ff < sfv_pkg::CharCountSat) begin
         char_count_in = char_count_ff + 4'd1;
      end

      if (!dot_seen_ff && cls.is_dot) begin
         dot_seen_in = 1'b1;
      end else begin
         if (!cls.allowed) begin
            bad_char_in = 1'b1;
         end
         if (!dot_seen_ff) begin
            // base character
            if (cls.up) case_flags_in[0] = 1'b1;
            if (cls.lo) case_flags_in[1] = 1'b1;
            if (base_count_ff < 4'(sfv_pkg::BaseLen)) begin
               for (int i = 0; i < sfv_pkg::BaseLen; i++) begin
                  if (base_count_ff[2:0] == 3'(i)) begin
                     base_accum_in[8*(sfv_pkg::BaseLen-1-i) +: 8] = cls.folded;
                  end
               end
               if (cls.lo) lower_flags_in[0] = 1'b1;
            end
            if (base_count_ff < sfv_pkg::BaseCountSat) begin
               base_count_in = base_count_ff + 4'd1;
            end
         end else begin
            // extension character
            if (cls.up) case_flags_in[2] = 1'b1;
            if (cls.lo) case_flags_in[3] = 1'b1;
            if (ext_count_ff < 3'(sfv_pkg::ExtLen)) begin
               for (int i = 0; i < sfv_pkg::ExtLen; i++) begin
                  if (ext_count_ff[1:0] == 2'(i)) begin
                     ext_accum_in[8*(sfv_pkg::ExtLen-1-i) +: 8] = cls.folded;
                  end
               end
               if (cls.lo) lower_flags_in[1] = 1'b1;
            end
            if (ext_count_ff < sfv_pkg::ExtCountSat) begin
               ext_count_in = ext_count_ff + 3'd1;
            end
         end
      end
   end

   // result from the updated state
   always_comb begin
      result.valid_res  = !bad_char_in
                          && (char_count_in <= 4'(sfv_pkg::MaxNameLen))
                          && (base_count_in >= 4'd1)
                          && (base_count_in <= 4'(sfv_pkg::BaseLen))
                          && (ext_count_in <= 3'(sfv_pkg::ExtLen))
                          && (case_flags_in[1:0] != 2'b11)
                          && (case_flags_in[3:2] != 2'b11);
      result.lower_base = lower_flags_in[0];
      result.lower_ext  = lower_flags_in[1];
      result.base_name  = base_accum_in;
      result.ext_name   = ext_accum_in;
   end

   assign push = accept && last;

   // state registers, back to reset values after each name
   always_ff @(posedge clock) begin
      if (reset || push) begin
         char_count_ff  <= '0;
         dot_seen_ff    <= 1'b0;
         base_count_ff  <= '0;
         ext_count_ff   <= '0;
         bad_char_ff    <= 1'b0;
         case_flags_ff  <= '0;
         lower_flags_ff <= '0;
         base_accum_ff  <= sfv_pkg::BaseSpaces;
         ext_accum_ff   <= sfv_pkg::ExtSpaces;
      end else if (accept) begin
         char_count_ff  <= char_count_in;
         dot_seen_ff    <= dot_seen_in;
         base_count_ff  <= base_count_in;
         ext_count_ff   <= ext_count_in;
         bad_char_ff    <= bad_char_in;
         case_flags_ff  <= case_flags_in;
         lower_flags_ff <= lower_flags_in;
         base_accum_ff  <= base_accum_in;
         ext_accum_ff   <= ext_accum_in;
      end
   end

endmodule

@@ hdl/sfv_rsp_buffer.sv @@
// two-entry result buffer: output register plus skid register, so the
// input side keeps flowing while a result waits; depends on sfv_pkg
module sfv_rsp_buffer (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfv_pkg::rsp_type push_data,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output sfv_pkg::rsp_type out_data
);

   logic             main_valid_ff;
   logic             skid_valid_ff;
   sfv_pkg::rsp_type main_data_ff;
   sfv_pkg::rsp_type skid_data_ff;
   logic             pop;

   assign pop       = main_valid_ff && out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_ff <= skid_data_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_data_ff <= push_data;
         end else begin
            main_data_ff <= push_data;
         end
      end
   end

endmodule

@@ hdl/short_name_validate_format_unit.sv @@
// FAT 8.3 short name checker and formatter, one character per item.
// The result is registered in the buffer when the last character is taken.
// Throughput: one character per cycle; the two-entry result buffer keeps input
// flowing while one result waits, and ready drops only when both entries are full.
// Reset (synchronous, active high): counters and flags clear, the formatted
// name returns to all spaces and the result buffer empties.
module short_name_validate_format_unit (
   input logic       clock,
   input logic       reset,
   sfv_req_if.sink   req_chan,
   sfv_rsp_if.source rsp_chan
);

   sfv_pkg::char_class_type cls;
   sfv_pkg::rsp_type        result;
   sfv_pkg::rsp_type        out_data;
   logic                    in_ready;
   logic                    accept;
   logic                    push;

   assign req_chan.ready = in_ready;
   assign accept         = req_chan.valid && in_ready;

   // classify the incoming character
   sfv_char_class u_class (
      .ch  (req_chan.ch),
      .cls (cls)
   );

   // per-name state and result forming
   sfv_name_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .last   (req_chan.last),
      .cls    (cls),
      .push   (push),
      .result (result)
   );

   // result buffer
   sfv_rsp_buffer u_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .in_ready  (in_ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   assign rsp_chan.valid_res  = out_data.valid_res;
   assign rsp_chan.lower_base = out_data.lower_base;
   assign rsp_chan.lower_ext  = out_data.lower_ext;
   assign rsp_chan.base_name  = out_data.base_name;
   assign rsp_chan.ext_name   = out_data.ext_name;

endmodule
